@@ rtl/spwm_pkg.sv @@
// shared types, constants and codes for the staggered pwm update scheduler
package spwm_pkg;

    // field widths
    localparam int DUTY_W     = 13;
    localparam int TIMER_W    = 3;
    localparam int COUNT_W    = 4;
    localparam int MAP_SLOTS  = 8;
    localparam int MAP_W      = TIMER_W * MAP_SLOTS;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = MAP_W;

    // default build size
    localparam int DEF_MAX_SLOTS = 8;

    // full on duty, period is fixed at this many counts
    localparam logic [DUTY_W-1:0] FULL_SCALE = DUTY_W'(4096);

    // register reset values
    localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = COUNT_W'(4);
    localparam logic [MAP_W-1:0]   SLOT_MAP_RST   = '0;

    // item operation codes
    typedef enum logic
    {
        OP_SET  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_SLOT_COUNT = 1'b0,
        REG_SLOT_MAP   = 1'b1
    } cfg_reg_t;

    // sequencer states
    typedef enum logic
    {
        ST_IDLE,
        ST_COMMIT
    } state_t;

    // input beat
    typedef struct packed
    {
        logic [0:0]         operation;
        logic [TIMER_W-1:0] timer_id;
        logic [DUTY_W-1:0]  duty;
    } in_item_t;

    // result beat
    typedef struct packed
    {
        logic [TIMER_W-1:0] commit_timer;
        logic [DUTY_W-1:0]  commit_duty;
    } res_item_t;

    // one slot entry as held in memory
    typedef struct packed
    {
        logic              pending;
        logic [DUTY_W-1:0] duty;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

@@ rtl/spwm_ram.sv @@
// generic simple dual port ram, one write port and one registered read port
module spwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/spwm_slot_sel.sv @@
// slot selection: active count, timer match and round-robin pointer step
module spwm_slot_sel
    import spwm_pkg::*;
#(
    parameter int USED_SLOTS = DEF_MAX_SLOTS,
    parameter int IDX_W      = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1
) (
    input  logic [COUNT_W-1:0] slot_count,
    input  logic [MAP_W-1:0]   slot_map,
    input  logic [TIMER_W-1:0] timer_id,
    input  logic [IDX_W-1:0]   pointer,
    output logic               hit,
    output logic [IDX_W-1:0]   match_slot,
    output logic [IDX_W-1:0]   tick_slot,
    output logic [TIMER_W-1:0] tick_timer,
    output logic [IDX_W-1:0]   next_ptr
);

    logic [COUNT_W-1:0] active;
    logic [IDX_W:0]     step;

    // active slot count, zero acts as one, capped at the built slots
    always_comb
    begin
        active = slot_count;
        if (active == '0)
        begin
            active = COUNT_W'(1);
        end
        if (active > COUNT_W'(USED_SLOTS))
        begin
            active = COUNT_W'(USED_SLOTS);
        end
    end

    // lowest active slot mapped to the requested timer
    always_comb
    begin
        hit        = 1'b0;
        match_slot = '0;
        for (int i = 0; i < USED_SLOTS; i++)
        begin
            if (!hit && (COUNT_W'(i) < active) &&
                (slot_map[TIMER_W*i +: TIMER_W] == timer_id))
            begin
                hit        = 1'b1;
                match_slot = IDX_W'(i);
            end
        end
    end

    // pointer past the active count falls back to slot 0
    assign tick_slot  = (COUNT_W'(pointer) >= active) ? '0 : pointer;
    assign tick_timer = slot_map[TIMER_W*tick_slot +: TIMER_W];

    // advance and wrap
    assign step     = {1'b0, tick_slot} + (IDX_W + 1)'(1);
    assign next_ptr = (COUNT_W'(step) >= active) ? '0 : step[IDX_W-1:0];

endmodule

@@ rtl/staggered_pwm_update_scheduler.sv @@
// Staggered PWM update scheduler. Shadow duty and pending mark of every slot sit
// in one small RAM with a registered read; a per-slot valid flop marks entries
// written since reset, and an entry not yet written reads as pending with duty 0,
// so no clearing pass is needed and the block takes items right after reset.
// A set item is matched on the slot map and, on a hit, written to the RAM. A tick
// item goes through the RAM read of the slot under the pointer, then the
// commit cycle, where result_strobe is high for that single cycle if the slot
// was pending and the cleared mark is written back. busy is high during the
// commit cycle. The result cannot be held off: whoever takes it must sample it
// in the cycle result_strobe is high. Configuration writes are always ready.
module staggered_pwm_update_scheduler
    import spwm_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  in_item_t              item,
    output logic                  result_strobe,
    output res_item_t             result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int USED_SLOTS = (MAX_SLOTS < MAP_SLOTS) ? MAX_SLOTS : MAP_SLOTS;
    localparam int IDX_W      = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;

    logic [COUNT_W-1:0]    slot_count_reg;
    logic [MAP_W-1:0]      slot_map_reg;
    state_t                state_reg;
    state_t                state_next;
    logic [IDX_W-1:0]      ptr_reg;
    logic [USED_SLOTS-1:0] valid_reg;
    logic [IDX_W-1:0]      tick_slot_reg;
    logic [TIMER_W-1:0]    tick_timer_reg;

    logic                  accept;
    logic                  is_tick;
    logic                  hit;
    logic [IDX_W-1:0]      match_slot;
    logic [IDX_W-1:0]      tick_slot;
    logic [TIMER_W-1:0]    tick_timer;
    logic [IDX_W-1:0]      next_ptr;
    logic [DUTY_W-1:0]     sat_duty;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    slot_entry_t           ram_wdata;
    logic                  ram_re;
    logic [ENTRY_W-1:0]    ram_rdata;
    slot_entry_t           entry;

    assign accept    = start && !busy;
    assign is_tick   = (item.operation == OP_TICK);
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= SLOT_COUNT_RST;
            slot_map_reg   <= SLOT_MAP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SLOT_COUNT: slot_count_reg <= cfg_data[COUNT_W-1:0];
                REG_SLOT_MAP:   slot_map_reg   <= cfg_data[MAP_W-1:0];
                default:        ;
            endcase
        end
    end

    // slot match and pointer step
    spwm_slot_sel #(
        .USED_SLOTS (USED_SLOTS),
        .IDX_W      (IDX_W)
    ) u_slot_sel (
        .slot_count (slot_count_reg),
        .slot_map   (slot_map_reg),
        .timer_id   (item.timer_id),
        .pointer    (ptr_reg),
        .hit        (hit),
        .match_slot (match_slot),
        .tick_slot  (tick_slot),
        .tick_timer (tick_timer),
        .next_ptr   (next_ptr)
    );

    // duty saturation at full scale
    assign sat_duty = (item.duty > FULL_SCALE) ? FULL_SCALE : item.duty;

    // slot state memory
    spwm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (USED_SLOTS),
        .AW    (IDX_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (tick_slot),
        .rdata (ram_rdata)
    );

    // unwritten entries read as pending with zero duty
    always_comb
    begin
        if (valid_reg[tick_slot_reg])
        begin
            entry = slot_entry_t'(ram_rdata);
        end
        else
        begin
            entry.pending = 1'b1;
            entry.duty    = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_tick)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and memory access
    always_comb
    begin
        busy          = 1'b0;
        result_strobe = 1'b0;
        ram_re        = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = match_slot;
        ram_wdata     = '{pending: 1'b1, duty: sat_duty};
        unique case (state_reg)
            ST_IDLE:
            begin
                ram_re = start && is_tick;
                ram_we = start && !is_tick && hit;
            end
            ST_COMMIT:
            begin
                busy          = 1'b1;
                result_strobe = entry.pending;
                ram_we        = entry.pending;
                ram_waddr     = tick_slot_reg;
                ram_wdata     = '{pending: 1'b0, duty: entry.duty};
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign result.commit_timer = tick_timer_reg;
    assign result.commit_duty  = entry.duty;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && is_tick)
            begin
                ptr_reg <= next_ptr;
            end
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // slot under the pointer, held for the commit cycle
    always_ff @(posedge clk)
    begin
        if (accept && is_tick)
        begin
            tick_slot_reg  <= tick_slot;
            tick_timer_reg <= tick_timer;
        end
    end

endmodule
